>>> hw/rtl/bct_pkg.sv
// Shared types, codes and character-class helpers for the configuration tokenizer.
// No dependencies; imported by bct_parse, bct_emit and block_config_tokenizer_core.
package bct_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned EventW = 4;
    localparam int unsigned RepW   = 3;   // up to seven replayed letters
    localparam int unsigned CountW = 4;   // up to nine results per byte
    localparam int unsigned LocLen = 8;   // letters in "location"

    localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_VT     = 8'h0B;
    localparam logic [ByteW-1:0] CH_FF     = 8'h0C;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
    localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;
    localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
    localparam logic [ByteW-1:0] CH_UNDER  = 8'h5F;
    localparam logic [ByteW-1:0] CH_DASH   = 8'h2D;
    localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
    localparam logic [ByteW-1:0] CH_DOT    = 8'h2E;
    localparam logic [ByteW-1:0] CH_COLON  = 8'h3A;
    localparam logic [ByteW-1:0] CH_LOW_L  = 8'h6C;
    localparam logic [ByteW-1:0] CH_LOW_S  = 8'h73;
    localparam logic [ByteW-1:0] CASE_BIT  = 8'h20;

    typedef enum logic [EventW-1:0] {
        EV_SRV_OPEN  = 4'd0,
        EV_SRV_DIR   = 4'd1,
        EV_SRV_KEY   = 4'd2,
        EV_SRV_VAL   = 4'd3,
        EV_LOC_START = 4'd4,
        EV_PATH      = 4'd5,
        EV_LOC_DIR   = 4'd6,
        EV_LOC_KEY   = 4'd7,
        EV_LOC_VAL   = 4'd8,
        EV_ERROR     = 4'd9,
        EV_CHUNK_END = 4'd10
    } tok_event_t;

    // ST_SEEK..ST_SRV5: number of letters of "server" matched so far
    typedef enum logic [4:0] {
        ST_SEEK   = 5'd0,
        ST_SRV1   = 5'd1,
        ST_SRV2   = 5'd2,
        ST_SRV3   = 5'd3,
        ST_SRV4   = 5'd4,
        ST_SRV5   = 5'd5,
        ST_SPACE  = 5'd6,
        ST_OPEN   = 5'd7,
        ST_INSRV  = 5'd8,
        ST_SKEY   = 5'd9,
        ST_SVAL   = 5'd10,
        ST_TENT   = 5'd11,
        ST_LSPACE = 5'd12,
        ST_LPATH  = 5'd13,
        ST_LOPEN  = 5'd14,
        ST_INLOC  = 5'd15,
        ST_LKEY   = 5'd16,
        ST_LVAL   = 5'd17
    } parse_state_t;

    // Results caused by one byte: replayed letters, one main result, chunk end
    typedef struct packed {
        logic [CountW-1:0] count;
        logic [RepW-1:0]   rep_n;
        logic              main_v;
        tok_event_t        main_ev;
        logic [ByteW-1:0]  main_ch;
        logic              end_v;
        logic              end_failed;
    } tok_desc_t;

    function automatic logic [ByteW-1:0] server_char(input logic [2:0] idx);
        logic [ByteW-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h73; // s
            3'd1:    ch = 8'h65; // e
            3'd2:    ch = 8'h72; // r
            3'd3:    ch = 8'h76; // v
            3'd4:    ch = 8'h65; // e
            default: ch = 8'h72; // r
        endcase
        return ch;
    endfunction

    function automatic logic [ByteW-1:0] loc_char(input logic [RepW-1:0] idx);
        logic [ByteW-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h6C; // l
            3'd1:    ch = 8'h6F; // o
            3'd2:    ch = 8'h63; // c
            3'd3:    ch = 8'h61; // a
            3'd4:    ch = 8'h74; // t
            3'd5:    ch = 8'h69; // i
            3'd6:    ch = 8'h6F; // o
            default: ch = 8'h6E; // n
        endcase
        return ch;
    endfunction

    function automatic logic is_alpha(input logic [ByteW-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [ByteW-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_key(input logic [ByteW-1:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic logic is_value(input logic [ByteW-1:0] c);
        return is_key(c) || c == CH_DOT || c == CH_SLASH || c == CH_COLON;
    endfunction

    function automatic logic is_path(input logic [ByteW-1:0] c);
        return is_key(c) || c == CH_SLASH;
    endfunction

    function automatic logic is_space_any(input logic [ByteW-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR
            || c == CH_VT || c == CH_FF;
    endfunction

endpackage

>>> hw/rtl/bct_parse.sv
// Parser state machine: decodes one byte against the parse state into a result descriptor.
// Depends on bct_pkg.
module bct_parse (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [bct_pkg::ByteW-1:0] byte_in,
    input  logic                     last_in,
    output bct_pkg::tok_desc_t       desc
);
    import bct_pkg::*;

    parse_state_t      state_reg, state_next;
    logic [RepW-1:0]   cnt_reg, cnt_next;
    logic              err_reg, err_next;

    logic              fail;
    logic              err_after;
    logic [RepW-1:0]   rep_n;
    logic              main_v;
    tok_event_t        main_ev;
    logic [ByteW-1:0]  main_ch;
    logic [ByteW-1:0]  c;

    // k letters matched replay as k results; a zero count still gives the 'l'
    function automatic logic [RepW-1:0] rep_len(input logic [RepW-1:0] k);
        return (k == '0) ? RepW'(1) : k;
    endfunction

    assign c = byte_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEEK;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fail       = 1'b0;
        rep_n      = '0;
        main_v     = 1'b0;
        main_ev    = EV_ERROR;
        main_ch    = '0;

        if (!err_reg) begin
            unique case (state_reg)
                ST_SRV1, ST_SRV2, ST_SRV3, ST_SRV4, ST_SRV5: begin
                    if (is_alpha(c) && (c | CASE_BIT) == server_char(state_reg[2:0]))
                        state_next = parse_state_t'(state_reg + 5'd1);
                    else
                        fail = 1'b1;
                end
                ST_SPACE: begin
                    if (c == CH_SPACE) state_next = ST_OPEN;
                    else fail = 1'b1;
                end
                ST_OPEN: begin
                    if (c == CH_LBRACE) begin
                        main_v     = 1'b1;
                        main_ev    = EV_SRV_OPEN;
                        state_next = ST_INSRV;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_INSRV: begin
                    if (c == CH_LF) begin
                        state_next = state_reg;
                    end else if (c == CH_RBRACE) begin
                        state_next = ST_SEEK;
                    end else if (c == CH_LOW_L) begin
                        state_next = ST_TENT;
                        cnt_next   = RepW'(1);
                    end else if (is_key(c)) begin
                        main_v     = 1'b1;
                        main_ev    = EV_SRV_DIR;
                        main_ch    = c;
                        state_next = ST_SKEY;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_SKEY: begin
                    if (is_blank(c)) state_next = ST_SVAL;
                    else if (is_key(c)) begin
                        main_v  = 1'b1;
                        main_ev = EV_SRV_KEY;
                        main_ch = c;
                    end else fail = 1'b1;
                end
                ST_SVAL: begin
                    if (c == CH_SEMI) state_next = ST_INSRV;
                    else if (is_value(c) || is_blank(c)) begin
                        main_v  = 1'b1;
                        main_ev = EV_SRV_VAL;
                        main_ch = c;
                    end else fail = 1'b1;
                end
                ST_TENT: begin
                    if (c == loc_char(cnt_reg)) begin
                        if (cnt_reg == RepW'(LocLen - 1)) begin
                            main_v     = 1'b1;
                            main_ev    = EV_LOC_START;
                            cnt_next   = '0;
                            state_next = ST_LSPACE;
                        end else begin
                            cnt_next = cnt_reg + RepW'(1);
                        end
                    end else begin
                        // mismatch: replay the letters, then handle the byte as in ST_SKEY
                        rep_n      = rep_len(cnt_reg);
                        cnt_next   = '0;
                        state_next = ST_SKEY;
                        if (is_blank(c)) state_next = ST_SVAL;
                        else if (is_key(c)) begin
                            main_v  = 1'b1;
                            main_ev = EV_SRV_KEY;
                            main_ch = c;
                        end else fail = 1'b1;
                    end
                end
                ST_LSPACE: begin
                    if (is_blank(c)) state_next = ST_LPATH;
                    else fail = 1'b1;
                end
                ST_LPATH: begin
                    if (is_blank(c)) state_next = ST_LOPEN;
                    else if (is_path(c)) begin
                        main_v  = 1'b1;
                        main_ev = EV_PATH;
                        main_ch = c;
                    end else fail = 1'b1;
                end
                ST_LOPEN: begin
                    if (is_blank(c)) state_next = state_reg;
                    else if (c == CH_LBRACE) state_next = ST_INLOC;
                    else fail = 1'b1;
                end
                ST_INLOC: begin
                    if (c == CH_LF) begin
                        state_next = state_reg;
                    end else if (c == CH_RBRACE) begin
                        state_next = ST_INSRV;
                    end else if (is_key(c)) begin
                        main_v     = 1'b1;
                        main_ev    = EV_LOC_DIR;
                        main_ch    = c;
                        state_next = ST_LKEY;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_LKEY: begin
                    if (is_blank(c)) state_next = ST_LVAL;
                    else if (is_key(c)) begin
                        main_v  = 1'b1;
                        main_ev = EV_LOC_KEY;
                        main_ch = c;
                    end else fail = 1'b1;
                end
                ST_LVAL: begin
                    if (c == CH_SEMI) state_next = ST_INLOC;
                    else if (is_value(c) || is_blank(c)) begin
                        main_v  = 1'b1;
                        main_ev = EV_LOC_VAL;
                        main_ch = c;
                    end else fail = 1'b1;
                end
                default: begin
                    // seeking "server"; unused codes behave the same
                    if (is_space_any(c)) state_next = state_reg;
                    else if ((c | CASE_BIT) == CH_LOW_S) state_next = ST_SRV1;
                    else fail = 1'b1;
                end
            endcase
        end

        if (fail) begin
            main_v  = 1'b1;
            main_ev = EV_ERROR;
            main_ch = '0;
        end
        err_after = err_reg | fail;

        // chunk ends mid-match: flush matched letters as a server key
        if (last_in && state_next == ST_TENT && !err_after) begin
            rep_n      = rep_len(cnt_next);
            cnt_next   = '0;
            state_next = ST_SKEY;
        end

        err_next = last_in ? 1'b0 : err_after;

        desc.rep_n      = rep_n;
        desc.main_v     = main_v;
        desc.main_ev    = main_ev;
        desc.main_ch    = main_ch;
        desc.end_v      = last_in;
        desc.end_failed = err_after;
        desc.count      = {1'b0, rep_n} + {{(CountW-1){1'b0}}, main_v}
                        + {{(CountW-1){1'b0}}, last_in};
    end

endmodule

>>> hw/rtl/bct_emit.sv
// Result sequencer: holds one byte's result descriptor and issues its results one per transfer.
// Depends on bct_pkg.
module bct_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  bct_pkg::tok_desc_t         desc_in,
    output logic                       desc_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    output logic [bct_pkg::EventW-1:0] m_tuser,
    output logic                       m_tlast
);
    import bct_pkg::*;

    tok_desc_t           desc_reg;
    logic                valid_reg;
    logic [CountW-1:0]   idx_reg;

    logic                is_last;
    tok_event_t          ev;
    logic [ByteW-1:0]    ch;
    logic                failed;

    assign is_last    = (idx_reg == desc_reg.count - CountW'(1));
    assign desc_ready = !valid_reg || (m_tready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (is_last) begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + CountW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) desc_reg <= desc_in;
    end

    always_comb begin
        failed = 1'b0;
        if (idx_reg < {1'b0, desc_reg.rep_n}) begin
            ev = (idx_reg == '0) ? EV_SRV_DIR : EV_SRV_KEY;
            ch = loc_char(idx_reg[RepW-1:0]);
        end else if (desc_reg.main_v && idx_reg == {1'b0, desc_reg.rep_n}) begin
            ev = desc_reg.main_ev;
            ch = desc_reg.main_ch;
        end else begin
            ev     = EV_CHUNK_END;
            ch     = '0;
            failed = desc_reg.end_failed;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = ev;
    assign m_tdata  = {7'b0, failed, ch};
    assign m_tlast  = is_last;

endmodule

>>> hw/rtl/block_config_tokenizer_core.sv
// Top level of the configuration-text tokenizer: input register, parser and result sequencer.
// Depends on bct_pkg, bct_parse and bct_emit.
//
// Usage
//   s_ channel: one text byte per transfer in s_tdata[7:0]; s_tlast marks the
//   final byte of a chunk. m_ channel: one token per transfer, kind in
//   m_tuser[3:0], character in m_tdata[7:0], chunk-failed flag in m_tdata[8];
//   m_tlast marks the last token caused by one input byte.
//   The first token of a byte is offered by the result sequencer once the byte
//   has passed the input register and been loaded into the sequencer.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and m_tready stays high. A byte yielding several tokens issues them one per
//   transfer, stalling the input until the last one; the longest case is a
//   seven-letter "location" replay plus key char plus chunk end. Bytes with no
//   token pass through the input register without touching the sequencer.
//   Reset (aresetn low, synchronous) empties both stages and returns the parser
//   to seeking the "server" keyword with no error latched.
//   When m_tready is low the pending token holds; the input register keeps
//   one further byte, then s_tready drops until the sequencer drains.
module block_config_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // chunk_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] token_char, [8] chunk_failed, rest zero
    output logic [3:0]  m_tuser,   // [3:0] token_event
    output logic        m_tlast    // run_end
);
    import bct_pkg::*;

    logic              in_valid_reg;
    logic [ByteW-1:0]  in_byte_reg;
    logic              in_last_reg;

    tok_desc_t         desc;
    logic              desc_ready;
    logic              advance;
    logic              load;

    // a byte leaves the input register when it yields nothing or the sequencer is free
    assign advance  = in_valid_reg && ((desc.count == '0) || desc_ready);
    assign load     = advance && (desc.count != '0);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bct_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .desc    (desc)
    );

    bct_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .desc_in    (desc),
        .desc_ready (desc_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
